FILE: rtl/assert_macros.svh
// Assertion macros shared by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LFU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("lfu cache assertion failed");
`define LFU_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("lfu cache forbidden condition seen");
`else
`define LFU_ASSERT(lbl, clk, rst_n, prop)
`define LFU_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/lfu_pkg.sv
// Shared types and constants of the LFU cache.
package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int STAMP_W = 64;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
	localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
	localparam logic [VAL_W-1:0] PUT_VALUE  = 32'h0000_0000;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic commit;
		logic post;
	} cmd_t;

	typedef struct packed {
		logic cap_zero;
		logic scan_last;
		logic out_busy;
	} sts_t;

endpackage

FILE: rtl/lfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [ADDR_W-1:0]        raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/lfu_ctrl.sv
// Request sequencer of the LFU cache: accept, scan, drain, commit, post.
module lfu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  lfu_pkg::sts_t sts,
	output lfu_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_POST
	} state_t;

	state_t state_q;

	assign s_tready    = (state_q == ST_IDLE);
	assign cmd.load    = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.scan_rd = (state_q == ST_SCAN);
	assign cmd.commit  = (state_q == ST_COMMIT);
	assign cmd.post    = (state_q == ST_POST) && !sts.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= sts.cap_zero ? ST_POST : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_POST;
				end
				ST_POST: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/lfu_dp.sv
// Datapath of the LFU cache: entry store, scan compare, update and result register.
module lfu_dp #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]       cfg_wdata,
	input  logic                            req_kind,
	input  logic [lfu_pkg::KEY_W-1:0]       req_key,
	input  logic [lfu_pkg::VAL_W-1:0]       req_value,
	input  lfu_pkg::cmd_t                   cmd,
	output lfu_pkg::sts_t                   sts,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic                            rsp_hit,
	output logic [lfu_pkg::VAL_W-1:0]       rsp_value
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	localparam int KEY_LO = 0;
	localparam int VAL_LO = KEY_LO + lfu_pkg::KEY_W;
	localparam int CNT_LO = VAL_LO + lfu_pkg::VAL_W;
	localparam int STP_LO = CNT_LO + COUNT_BITS;
	localparam int WORD_W = STP_LO + lfu_pkg::STAMP_W;

	localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
	localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(ENTRIES - 1);
	localparam logic [OCC_W-1:0]      OCC_MAX  = OCC_W'(ENTRIES);

	// Control state.
	logic [lfu_pkg::CAP_W-1:0]   cap_q;
	logic [ENTRIES-1:0]          valid_q;
	logic [ENTRIES-1:0]          valid_d;
	logic [OCC_W-1:0]            occ_q;
	logic [lfu_pkg::STAMP_W-1:0] clock_q;
	logic                        rd_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [IDX_W-1:0]            scan_q;
	logic                        out_valid_q;

	// Request and scan results.
	logic                        kind_q;
	logic [lfu_pkg::KEY_W-1:0]   key_q;
	logic [lfu_pkg::VAL_W-1:0]   wval_q;
	logic                        found_q;
	logic [IDX_W-1:0]            found_idx_q;
	logic [lfu_pkg::VAL_W-1:0]   found_val_q;
	logic [COUNT_BITS-1:0]       found_cnt_q;
	logic                        vic_ok_q;
	logic [IDX_W-1:0]            vic_idx_q;
	logic [COUNT_BITS-1:0]       vic_cnt_q;
	logic [lfu_pkg::STAMP_W-1:0] vic_stp_q;
	logic                        free_ok_q;
	logic [IDX_W-1:0]            free_idx_q;
	logic                        out_hit_q;
	logic [lfu_pkg::VAL_W-1:0]   out_val_q;

	// Store port and decode.
	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	logic [WORD_W-1:0]           ram_wdata;
	logic [WORD_W-1:0]           ram_rdata;
	logic                        e_valid;
	logic [lfu_pkg::KEY_W-1:0]   e_key;
	logic [lfu_pkg::VAL_W-1:0]   e_val;
	logic [COUNT_BITS-1:0]       e_cnt;
	logic [lfu_pkg::STAMP_W-1:0] e_stp;
	logic                        e_better;
	logic [lfu_pkg::STAMP_W-1:0] clock_next;
	logic                        is_put;
	logic                        occ_full;
	logic                        evict;
	logic                        insert;
	logic [IDX_W-1:0]            slot;
	logic [COUNT_BITS-1:0]       hit_cnt;
	logic [lfu_pkg::VAL_W-1:0]   hit_val;
	logic                        res_hit;
	logic [lfu_pkg::VAL_W-1:0]   res_val;

	lfu_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.scan_rd),
		.raddr(scan_q),
		.rdata(ram_rdata)
	);

	assign e_valid  = valid_q[idx_s1];
	assign e_key    = ram_rdata[VAL_LO-1:KEY_LO];
	assign e_val    = ram_rdata[CNT_LO-1:VAL_LO];
	assign e_cnt    = ram_rdata[STP_LO-1:CNT_LO];
	assign e_stp    = ram_rdata[WORD_W-1:STP_LO];
	assign e_better = !vic_ok_q || (e_cnt < vic_cnt_q) ||
		((e_cnt == vic_cnt_q) && (e_stp < vic_stp_q));

	assign clock_next = clock_q + lfu_pkg::STAMP_W'(1);
	assign is_put     = (kind_q == lfu_pkg::KIND_PUT);
	assign occ_full   = ({{lfu_pkg::CAP_W{1'b0}}, occ_q} >= {{OCC_W{1'b0}}, cap_q}) ||
		(occ_q == OCC_MAX);
	assign evict      = occ_full && vic_ok_q;
	assign insert     = is_put && !found_q && (evict || free_ok_q);
	assign slot       = (evict && (!free_ok_q || (vic_idx_q < free_idx_q))) ?
		vic_idx_q : free_idx_q;
	assign hit_cnt    = (found_cnt_q == CNT_MAX) ? found_cnt_q : found_cnt_q + CNT_ONE;
	assign hit_val    = is_put ? wval_q : found_val_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = found_idx_q;
		ram_wdata = {clock_next, hit_cnt, hit_val, key_q};
		valid_d   = valid_q;
		if (cmd.commit) begin
			if (found_q) begin
				ram_we = 1'b1;
			end else if (insert) begin
				ram_we    = 1'b1;
				ram_waddr = slot;
				ram_wdata = {clock_next, CNT_ONE, wval_q, key_q};
				if (evict) begin
					valid_d[vic_idx_q] = 1'b0;
				end
				valid_d[slot] = 1'b1;
			end
		end
	end

	assign res_hit = found_q;
	assign res_val = is_put ? lfu_pkg::PUT_VALUE :
		(found_q ? found_val_q : lfu_pkg::MISS_VALUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= lfu_pkg::CAP_RESET;
			valid_q     <= '0;
			occ_q       <= '0;
			clock_q     <= '0;
			rd_s1       <= 1'b0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q   <= cfg_wdata;
				valid_q <= '0;
				occ_q   <= '0;
				clock_q <= '0;
			end else if (cmd.commit && (found_q || insert)) begin
				valid_q <= valid_d;
				clock_q <= clock_next;
				if (insert && !evict) begin
					occ_q <= occ_q + OCC_W'(1);
				end
			end
			rd_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				scan_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_q <= scan_q + IDX_W'(1);
			end
			if (cmd.post) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (cmd.load) begin
			kind_q    <= req_kind;
			key_q     <= req_key;
			wval_q    <= req_value;
			found_q   <= 1'b0;
			vic_ok_q  <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (rd_s1) begin
			if (e_valid && (e_key == key_q)) begin
				found_q     <= 1'b1;
				found_idx_q <= idx_s1;
				found_val_q <= e_val;
				found_cnt_q <= e_cnt;
			end
			if (e_valid && e_better) begin
				vic_ok_q  <= 1'b1;
				vic_idx_q <= idx_s1;
				vic_cnt_q <= e_cnt;
				vic_stp_q <= e_stp;
			end
			if (!e_valid && !free_ok_q) begin
				free_ok_q  <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
		if (cmd.post) begin
			out_hit_q <= res_hit;
			out_val_q <= res_val;
		end
	end

	assign sts.cap_zero  = (cap_q == '0);
	assign sts.scan_last = (scan_q == IDX_LAST);
	assign sts.out_busy  = out_valid_q && !rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp_hit   = out_hit_q;
	assign rsp_value = out_val_q;

endmodule

FILE: rtl/lfu_cache_lru_tiebreak.sv
// Top level of the LFU cache with least-recently-used tie-break.
//
//   Channel   Direction  Payload
//   s_*       in         tuser: kind; tdata: lookup_key, write_value
//   m_*       out        tuser: hit; tdata: read_value
//   cfg_*     in         capacity write, clears the store
//
// From acceptance to the result register a request passes the scan state, one entry a cycle
// through the store's single read port, then drain, commit and post. A new request is accepted
// only after the last one has left post; with capacity zero, acceptance leads straight to post.
// Reset and capacity writes clear the valid bits at once; there is no clearing pass.
// The post cycle stalls while the previous result still waits for m_tready.
`include "assert_macros.svh"

module lfu_cache_lru_tiebreak #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [63:0]               s_tdata,  // lookup_key, write_value
	input  logic                      s_tuser,  // kind
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,  // read_value
	output logic                      m_tuser   // hit
);

	lfu_pkg::cmd_t cmd;
	lfu_pkg::sts_t sts;

	lfu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lfu_dp #(
		.ENTRIES   (ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_kind (s_tuser),
		.req_key  (s_tdata[31:0]),
		.req_value(s_tdata[63:32]),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(m_tvalid),
		.rsp_ready(m_tready),
		.rsp_hit  (m_tuser),
		.rsp_value(m_tdata)
	);

	`LFU_NEVER(a_idle_no_work, clk, arst_n, s_tready && (cmd.scan_rd || cmd.commit))
	`LFU_ASSERT(a_one_at_a_time, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready)
	`LFU_ASSERT(a_post_when_free, clk, arst_n, cmd.post |-> !(m_tvalid && !m_tready))
	`LFU_NEVER(a_commit_cap_zero, clk, arst_n, cmd.commit && sts.cap_zero)

endmodule

FILE: bench/tb_lfu_cache_lru_tiebreak.sv
// Self-checking testbench for the LFU cache with least-recently-used tie-break.
`timescale 1ns / 100ps

module tb_lfu_cache_lru_tiebreak;

	localparam int SLOTS = 16;
	localparam int SETTLE = SLOTS + 8;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic        hit;
		logic [31:0] value;
	} answer_t;

	class cache_mirror;
		bit [4:0]  cap_eff;
		bit        slot_used [SLOTS];
		bit [31:0] slot_key [SLOTS];
		bit [31:0] slot_val [SLOTS];
		bit [15:0] slot_hits [SLOTS];
		bit [63:0] slot_stamp [SLOTS];
		bit [63:0] tick;
		int        fill;
		answer_t   answers_due [$];
		int        errors;
		int        checked;
		int        hits_seen;

		function void configure(bit [4:0] cap);
			cap_eff = (cap > SLOTS) ? 5'(SLOTS) : cap;
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
				slot_key[i] = '0;
				slot_val[i] = '0;
				slot_hits[i] = '0;
				slot_stamp[i] = '0;
			end
			tick = '0;
			fill = 0;
		endfunction

		function void log_request(logic kind, bit [31:0] key, bit [31:0] wval);
			answer_t due;
			int found;
			int victim;
			int spot;
			due.hit = 1'b0;
			due.value = (kind == lfu_pkg::KIND_PUT) ? lfu_pkg::PUT_VALUE : lfu_pkg::MISS_VALUE;
			found = -1;
			victim = -1;
			spot = -1;
			if (cap_eff != 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (found < 0 && slot_used[i] && slot_key[i] == key)
						found = i;
				if (found >= 0) begin
					due.hit = 1'b1;
					if (kind == lfu_pkg::KIND_PUT)
						slot_val[found] = wval;
					else
						due.value = slot_val[found];
					if (slot_hits[found] != 16'hFFFF)
						slot_hits[found]++;
					tick++;
					slot_stamp[found] = tick;
				end else if (kind == lfu_pkg::KIND_PUT) begin
					if (fill >= cap_eff) begin
						for (int i = 0; i < SLOTS; i++)
							if (slot_used[i] && (victim < 0 ||
							    slot_hits[i] < slot_hits[victim] ||
							    (slot_hits[i] == slot_hits[victim] &&
							     slot_stamp[i] < slot_stamp[victim])))
								victim = i;
						if (victim >= 0) begin
							slot_used[victim] = 1'b0;
							fill--;
						end
					end
					for (int i = 0; i < SLOTS; i++)
						if (spot < 0 && !slot_used[i])
							spot = i;
					if (spot >= 0) begin
						slot_used[spot] = 1'b1;
						slot_key[spot] = key;
						slot_val[spot] = wval;
						slot_hits[spot] = 16'd1;
						tick++;
						slot_stamp[spot] = tick;
						fill++;
					end
				end
			end
			answers_due.push_back(due);
		endfunction

		function void check_answer(logic hit, logic [31:0] value);
			answer_t due;
			if (answers_due.size() == 0) begin
				$error("result with no request outstanding: hit %0b read_value %h", hit, value);
				errors++;
			end else begin
				due = answers_due.pop_front();
				checked++;
				if (due.hit)
					hits_seen++;
				if (hit !== due.hit) begin
					$error("hit mismatch: expected %0b, actual %0b", due.hit, hit);
					errors++;
				end
				if (value !== due.value) begin
					$error("read_value mismatch: expected %h, actual %h", due.value, value);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;

	cache_mirror mirror;
	int          give_idle;
	int          take_idle;
	int          stall_cycles;
	int          cap_writes;
	bit [31:0]   key_pool [$];

	lfu_cache_lru_tiebreak uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= take_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			mirror.check_answer(m_tuser, m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timed out waiting for a handshake.");
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_request(logic kind, bit [31:0] key, bit [31:0] wval);
		while ($urandom_range(99) < give_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = {wval, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		mirror.log_request(kind, key, wval);
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (mirror.answers_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_capacity(bit [4:0] cap);
		settle();
		cfg_we = 1'b1;
		cfg_wdata = cap;
		@(negedge clk);
		cfg_we = 1'b0;
		mirror.configure(cap);
		cap_writes++;
	endtask

	function automatic bit [31:0] pick_key();
		if ($urandom_range(7) == 0)
			return $urandom;
		return key_pool[$urandom_range(key_pool.size() - 1)];
	endfunction

	task automatic run_random(int count, int pool_size, int hold_at);
		key_pool.delete();
		repeat (pool_size) key_pool.push_back($urandom);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				settle();
			send_request(logic'($urandom_range(1)), pick_key(), $urandom);
		end
	endtask

	initial begin
		mirror = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = lfu_pkg::KIND_GET;
		m_tready = 1'b0;
		stall_cycles = 0;
		cap_writes = 0;
		give_idle = 24;
		take_idle = 80;
		mirror.configure(lfu_pkg::CAP_RESET);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(lfu_pkg::KIND_GET, 32'h0000_0000, 32'h1234_5678);
		send_request(lfu_pkg::KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(lfu_pkg::KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(lfu_pkg::KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(lfu_pkg::KIND_PUT, 32'h0000_0000, 32'h0000_0000);
		send_request(lfu_pkg::KIND_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(lfu_pkg::KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(lfu_pkg::KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0005);
		send_request(lfu_pkg::KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);

		write_capacity(5'd0);
		send_request(lfu_pkg::KIND_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(lfu_pkg::KIND_PUT, 32'h0000_0007, 32'h0000_0009);
		send_request(lfu_pkg::KIND_GET, 32'h0000_0007, 32'h0000_0000);

		write_capacity(5'd1);
		send_request(lfu_pkg::KIND_PUT, 32'h0000_0001, 32'h0000_0011);
		send_request(lfu_pkg::KIND_PUT, 32'h0000_0002, 32'h0000_0022);
		send_request(lfu_pkg::KIND_GET, 32'h0000_0001, 32'h0000_0000);
		send_request(lfu_pkg::KIND_GET, 32'h0000_0002, 32'h0000_0000);

		// Equal counts evict the older entry; afterwards the lower count loses.
		write_capacity(5'd2);
		send_request(lfu_pkg::KIND_PUT, 32'h0000_00A1, 32'h0000_0A01);
		send_request(lfu_pkg::KIND_PUT, 32'h0000_00B2, 32'h0000_0B02);
		send_request(lfu_pkg::KIND_PUT, 32'h0000_00C3, 32'h0000_0C03);
		send_request(lfu_pkg::KIND_GET, 32'h0000_00A1, 32'h0000_0000);
		send_request(lfu_pkg::KIND_GET, 32'h0000_00B2, 32'h0000_0000);
		send_request(lfu_pkg::KIND_PUT, 32'h0000_00D4, 32'h0000_0D04);
		send_request(lfu_pkg::KIND_GET, 32'h0000_00C3, 32'h0000_0000);
		send_request(lfu_pkg::KIND_GET, 32'h0000_00D4, 32'h0000_0000);

		write_capacity(5'd3);
		run_random(320, 6, 160);

		give_idle = 80;
		take_idle = 24;
		write_capacity(5'd31);
		run_random(320, 24, -1);

		give_idle = 0;
		take_idle = 0;
		write_capacity(5'd17);
		run_random(310, 12, -1);

		settle();
		$display("Checked %0d results, %0d of them hits, over %0d capacity writes from 0 to 31.",
			mirror.checked, mirror.hits_seen, cap_writes);
		$display("Directed evictions, capacity corners and random traffic under back-pressure ran.");
		if (mirror.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_ram.sv
rtl/lfu_ctrl.sv
rtl/lfu_dp.sv
rtl/lfu_cache_lru_tiebreak.sv
bench/tb_lfu_cache_lru_tiebreak.sv
